// ===== sv/dsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants of the dot-star pattern matcher.
// ----------------------------------------------------------------------------
package dsm_pkg;

	localparam logic [7:0] SYM_ANY  = 8'h2E;
	localparam logic [7:0] SYM_STAR = 8'h2A;
	localparam logic [7:0] SYM_NUL  = 8'h00;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_PATTERN = 2'd1,
		OP_TEXT    = 2'd2,
		OP_END     = 2'd3
	} op_t;

	// per-cell control from the sequencing logic
	typedef struct packed {
		logic clear;
		logic load;
		logic star;
		logic step;
		logic valid;
		logic fresh;
	} cell_ctrl_t;

	// signals handed from one cell to the next
	typedef struct packed {
		logic eff;
		logic nxt;
		logic empty;
	} cell_link_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;

endpackage

// ===== sv/dsm_if.sv =====
// ----------------------------------------------------------------------------
// dsm_item_if / dsm_result_if
// Valid/ready channels for requests into and results out of the matcher.
// ----------------------------------------------------------------------------
interface dsm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] symbol;

	modport source (output valid, output op, output symbol, input ready);
	modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface dsm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== sv/dsm_cell.sv =====
// ----------------------------------------------------------------------------
// dsm_cell
// One pattern token: its byte, its star flag and its bit of the match row.
// ----------------------------------------------------------------------------
module dsm_cell
	import dsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic [7:0] symbol,
	input  cell_link_t link_l,
	output cell_link_t link_r
);

	logic [7:0] tok_q;
	logic       starred_q;
	logic       row_q;
	logic       eq;
	logic       empty_bit;
	logic       eff_bit;
	logic       nxt_bit;

	assign eq        = (tok_q == SYM_ANY) || (tok_q == symbol);
	assign empty_bit = ctrl.valid & starred_q & link_l.empty;
	assign eff_bit   = ctrl.fresh ? empty_bit : row_q;
	assign nxt_bit   = ctrl.valid & (starred_q ? (link_l.nxt | (eq & eff_bit))
	                                          : (eq & link_l.eff));

	assign link_r.eff   = eff_bit;
	assign link_r.nxt   = nxt_bit;
	assign link_r.empty = empty_bit;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			tok_q <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			starred_q <= 1'b0;
			row_q     <= 1'b0;
		end else begin
			if (ctrl.clear || ctrl.load) begin
				starred_q <= 1'b0;
			end else if (ctrl.star) begin
				starred_q <= 1'b1;
			end
			if (ctrl.step) begin
				row_q <= nxt_bit;
			end
		end
	end

endmodule

// ===== sv/dsm_result_buf.sv =====
// ----------------------------------------------------------------------------
// dsm_result_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module dsm_result_buf
	import dsm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	dsm_result_if.source result
);

	logic    a_valid_q;
	logic    b_valid_q;
	result_t a_q;
	result_t b_q;
	logic    pop;

	assign pop   = a_valid_q & result.ready;
	assign space = ~b_valid_q;

	assign result.valid            = a_valid_q;
	assign result.matched          = a_q.matched;
	assign result.pattern_overflow = a_q.pattern_overflow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else begin
			if (!a_valid_q || pop) begin
				a_valid_q <= b_valid_q | push;
				b_valid_q <= 1'b0;
			end else if (push) begin
				b_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!a_valid_q || pop) begin
			a_q <= b_valid_q ? b_q : push_data;
		end else if (push) begin
			b_q <= push_data;
		end
	end

endmodule

// ===== sv/dot_star_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher
// Whole-text matcher for literal, '.' and starred tokens on a row of cells.
//
//   channel  dir  payload                      request moves
//   item     in   op[1:0], symbol[7:0]         clear / pattern / text / end
//   result   out  matched, pattern_overflow    one per end-of-text request
//
// one request per cycle, every op; a text byte ripples once along the cells
// the cell chain (one and/or pair per token) sets the cycle length
// end-of-text results go through a two-entry buffer, item.ready drops only
// when both entries are full
// reset empties the pattern and arms the row for an empty text, no sweep
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher
	import dsm_pkg::*;
#(
	parameter int MAX_TOKENS = 16
) (
	input  logic clk,
	input  logic arst_n,
	dsm_item_if.sink     item,
	dsm_result_if.source result
);

	localparam int CW = $clog2(MAX_TOKENS + 1);

	logic [CW-1:0] count_q;
	logic          star_armed_q;
	logic          overflow_q;
	logic          fresh_q;

	logic          accept;
	op_t           op;
	logic          do_clear;
	logic          do_text;
	logic          do_end;
	logic          pat_ok;
	logic          is_star;
	logic          has_room;
	logic          do_load;
	logic          do_drop;
	logic          do_star;
	logic          space;
	result_t       res;

	cell_ctrl_t            ctrl  [MAX_TOKENS];
	cell_link_t            links [MAX_TOKENS+1];
	logic [MAX_TOKENS:0]   eff_row;

	assign accept   = item.valid & item.ready;
	assign op       = op_t'(item.op);
	assign do_clear = accept && (op == OP_CLEAR);
	assign do_text  = accept && (op == OP_TEXT);
	assign do_end   = accept && (op == OP_END);
	assign pat_ok   = accept && (op == OP_PATTERN) && (item.symbol != SYM_NUL);
	assign is_star  = item.symbol == SYM_STAR;
	assign has_room = count_q < CW'(MAX_TOKENS);
	assign do_load  = pat_ok & ~is_star & has_room;
	assign do_drop  = pat_ok & ~is_star & ~has_room;
	assign do_star  = pat_ok & is_star & star_armed_q & (count_q != '0);

	assign item.ready = space;

	assign links[0].eff   = fresh_q;
	assign links[0].nxt   = 1'b0;
	assign links[0].empty = 1'b1;
	assign eff_row[0]     = fresh_q;

	for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
		assign ctrl[i].clear = do_clear;
		assign ctrl[i].load  = do_load && (count_q == CW'(i));
		assign ctrl[i].star  = do_star && (count_q == CW'(i + 1));
		assign ctrl[i].step  = do_text;
		assign ctrl[i].valid = CW'(i) < count_q;
		assign ctrl[i].fresh = fresh_q;
		assign eff_row[i+1]  = links[i+1].eff;

		dsm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl[i]),
			.symbol (item.symbol),
			.link_l (links[i]),
			.link_r (links[i+1])
		);
	end

	assign res.matched          = eff_row[count_q];
	assign res.pattern_overflow = overflow_q;

	dsm_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (do_end),
		.push_data (res),
		.space     (space),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			star_armed_q <= 1'b0;
			overflow_q   <= 1'b0;
			fresh_q      <= 1'b1;
		end else begin
			if (do_clear) begin
				count_q      <= '0;
				star_armed_q <= 1'b0;
				overflow_q   <= 1'b0;
				fresh_q      <= 1'b1;
			end else if (pat_ok) begin
				if (do_load) begin
					count_q <= count_q + CW'(1);
				end
				if (do_drop) begin
					overflow_q <= 1'b1;
				end
				star_armed_q <= do_load;
				fresh_q      <= 1'b1;
			end else if (do_text) begin
				fresh_q <= 1'b0;
			end else if (do_end) begin
				fresh_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TOKENS))
		else $error("token count beyond capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		do_clear |=> (count_q == '0) && !overflow_q && fresh_q && !star_armed_q)
		else $error("clear left pattern state behind");

	a_text_consumes_row: assert property (@(posedge clk) disable iff (!arst_n)
		do_text |=> !fresh_q)
		else $error("text byte did not update the row");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q && !do_clear |=> overflow_q)
		else $error("overflow flag lost without clear");
`endif

endmodule
